@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("never failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ hw/rtl/mpl_pkg.sv @@
// ----------------------------------------------------------------------------
// mpl_pkg
// shared types and constants of the marker point labeler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mpl_pkg;
  localparam int MaxPoints = 8;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);
  localparam int MaxModel = 5;
  localparam int MinModel = 3;

  localparam logic [1:0] ModeCap3 = 2'd0;
  localparam logic [1:0] ModeCap4 = 2'd1;
  localparam logic [1:0] ModeCap5 = 2'd2;
  localparam logic [1:0] ModeClip = 2'd3;

  localparam logic CfgModelMode = 1'b0;
  localparam logic CfgDeadzone  = 1'b1;

  localparam logic [1:0] StatMoved = 2'd0;
  localparam logic [1:0] StatHeld  = 2'd1;
  localparam logic [1:0] StatFew   = 2'd2;

  typedef enum logic [3:0] {
    S_COLLECT, S_TOP, S_SECOND, S_THIRD, S_FOURTH, S_FIFTH, S_SPLIT,
    S_CHECK, S_EMIT, S_FAIL
  } state_t;

  // scan kinds used by the datapath
  typedef enum logic [2:0] {
    K_MIN_Y, K_MAX_Y, K_MAX_X, K_MIN_X, K_LAST, K_FIRST
  } scan_t;

  typedef struct packed {
    logic             store;     // write incoming point
    logic             clr_cnt;
    logic             scan_go;   // start a scan
    scan_t            kind;
    logic [2:0]       dst;       // label slot of the scan result
    logic             split;     // five point reorder
    logic             chk_go;
    logic             commit;    // decide status, update deadzone
    logic             emit_go;
    logic             fail_go;
  } cmd_t;

  typedef struct packed {
    logic             scan_done;
    logic             chk_done;
    logic             emit_busy;
    logic [CntW-1:0]  count;
  } sts_t;
endpackage
`default_nettype wire

@@ hw/rtl/mpl_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpl_ctrl
// sequencer for collection, labelling scans, deadzone check and emission
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mpl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_xfer,
  input  wire logic               in_point_valid,
  input  wire logic               in_last_point,
  input  wire logic [1:0]         mode,
  input  wire mpl_pkg::sts_t      sts,
  output mpl_pkg::cmd_t           cmd,
  output logic                    in_ready
);
  mpl_pkg::state_t state_r, state_nxt;
  logic            go_r, go_nxt;   // scan, check or emission launched in this state
  logic [2:0]      need;
  logic            frame_end;

  assign need = (mode == mpl_pkg::ModeCap4) ? 3'd4 :
                (mode == mpl_pkg::ModeCap5) ? 3'd5 : 3'd3;
  assign frame_end = in_xfer && (!in_point_valid || in_last_point);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpl_pkg::S_COLLECT;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    go_nxt    = go_r;
    case (state_r)
      mpl_pkg::S_COLLECT: begin
        if (frame_end) begin
          // count seen here excludes a point stored this edge
          go_nxt = 1'b0;
          state_nxt = mpl_pkg::S_TOP;
        end
      end
      mpl_pkg::S_TOP: begin
        if (!go_r) begin
          if ({1'b0, sts.count} < {1'b0, need}) state_nxt = mpl_pkg::S_FAIL;
          else go_nxt = 1'b1;
        end else if (sts.scan_done) begin
          go_nxt = 1'b0; state_nxt = mpl_pkg::S_SECOND;
        end
      end
      mpl_pkg::S_SECOND: begin
        if (!go_r) go_nxt = 1'b1;
        else if (sts.scan_done) begin go_nxt = 1'b0; state_nxt = mpl_pkg::S_THIRD; end
      end
      mpl_pkg::S_THIRD: begin
        if (!go_r) go_nxt = 1'b1;
        else if (sts.scan_done) begin
          go_nxt = 1'b0;
          state_nxt = (mode == mpl_pkg::ModeCap3 || mode == mpl_pkg::ModeClip) ?
                      mpl_pkg::S_CHECK : mpl_pkg::S_FOURTH;
        end
      end
      mpl_pkg::S_FOURTH: begin
        if (!go_r) go_nxt = 1'b1;
        else if (sts.scan_done) begin
          go_nxt = 1'b0;
          state_nxt = (mode == mpl_pkg::ModeCap5) ? mpl_pkg::S_FIFTH : mpl_pkg::S_CHECK;
        end
      end
      mpl_pkg::S_FIFTH: begin
        if (!go_r) go_nxt = 1'b1;
        else if (sts.scan_done) begin go_nxt = 1'b0; state_nxt = mpl_pkg::S_SPLIT; end
      end
      mpl_pkg::S_SPLIT: state_nxt = mpl_pkg::S_CHECK;
      mpl_pkg::S_CHECK: begin
        if (!go_r) go_nxt = 1'b1;
        else if (sts.chk_done) begin go_nxt = 1'b0; state_nxt = mpl_pkg::S_EMIT; end
      end
      mpl_pkg::S_EMIT: begin
        if (!go_r) go_nxt = 1'b1;
        else if (!sts.emit_busy) begin go_nxt = 1'b0; state_nxt = mpl_pkg::S_COLLECT; end
      end
      mpl_pkg::S_FAIL: begin
        if (!go_r) go_nxt = 1'b1;
        else if (!sts.emit_busy) begin go_nxt = 1'b0; state_nxt = mpl_pkg::S_COLLECT; end
      end
      default: state_nxt = mpl_pkg::S_COLLECT;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.kind = mpl_pkg::K_MIN_Y;
    in_ready = 1'b0;
    case (state_r)
      mpl_pkg::S_COLLECT: begin
        in_ready  = 1'b1;
        cmd.store = in_xfer && in_point_valid;
      end
      mpl_pkg::S_TOP: begin
        cmd.scan_go = !go_r && !({1'b0, sts.count} < {1'b0, need});
        cmd.kind = mpl_pkg::K_MIN_Y; cmd.dst = 3'd0;
      end
      mpl_pkg::S_SECOND: begin
        cmd.scan_go = !go_r;
        cmd.kind = (mode == mpl_pkg::ModeClip) ? mpl_pkg::K_MAX_Y : mpl_pkg::K_MAX_X;
        cmd.dst = (mode == mpl_pkg::ModeClip) ? 3'd2 : 3'd1;
      end
      mpl_pkg::S_THIRD: begin
        cmd.scan_go = !go_r;
        cmd.kind = (mode == mpl_pkg::ModeClip) ? mpl_pkg::K_LAST : mpl_pkg::K_MIN_X;
        cmd.dst = (mode == mpl_pkg::ModeClip) ? 3'd1 : 3'd2;
      end
      mpl_pkg::S_FOURTH: begin
        cmd.scan_go = !go_r;
        cmd.kind = (mode == mpl_pkg::ModeCap4) ? mpl_pkg::K_LAST : mpl_pkg::K_FIRST;
        cmd.dst = 3'd3;
      end
      mpl_pkg::S_FIFTH: begin
        cmd.scan_go = !go_r; cmd.kind = mpl_pkg::K_FIRST; cmd.dst = 3'd4;
      end
      mpl_pkg::S_SPLIT: cmd.split = 1'b1;
      mpl_pkg::S_CHECK: begin
        cmd.chk_go = !go_r;
        cmd.commit = go_r && sts.chk_done;
      end
      mpl_pkg::S_EMIT: begin
        cmd.emit_go = !go_r;
        cmd.clr_cnt = go_r && !sts.emit_busy;
      end
      mpl_pkg::S_FAIL: begin
        cmd.fail_go = !go_r;
        cmd.clr_cnt = go_r && !sts.emit_busy;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ hw/rtl/mpl_datapath.sv @@
// ----------------------------------------------------------------------------
// mpl_datapath
// point stores, extreme scan unit, deadzone check and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mpl_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mpl_pkg::cmd_t      cmd,
  output mpl_pkg::sts_t           sts,
  input  wire logic [15:0]        in_point_x,
  input  wire logic [15:0]        in_point_y,
  input  wire logic [1:0]         mode,
  input  wire logic [7:0]         half_edge,
  input  wire logic               dz_clear,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_slot,
  output logic [15:0]             out_out_x,
  output logic [15:0]             out_out_y,
  output logic [2:0]              out_source_index,
  output logic [1:0]              out_status,
  output logic                    out_last_result
);
  localparam int N = mpl_pkg::MaxPoints;
  localparam int IW = mpl_pkg::IdxW;
  localparam int CW = mpl_pkg::CntW;

  logic [15:0] xs_r [N];
  logic [15:0] ys_r [N];
  logic [CW-1:0] cnt_r;
  logic [15:0] dzx_r [mpl_pkg::MaxModel];
  logic [15:0] dzy_r [mpl_pkg::MaxModel];
  logic        armed_r;
  logic [2:0]  dzn_r;
  logic [IW-1:0] idx_r [mpl_pkg::MaxModel];
  logic [N-1:0]  ex_r;

  logic [2:0]  need;
  assign need = (mode == mpl_pkg::ModeCap4) ? 3'd4 :
                (mode == mpl_pkg::ModeCap5) ? 3'd5 : 3'd3;

  // point stores and count
  always_ff @(posedge clk) begin
    if (cmd.store && cnt_r < CW'(N)) begin
      xs_r[cnt_r[IW-1:0]] <= in_point_x;
      ys_r[cnt_r[IW-1:0]] <= in_point_y;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (cmd.clr_cnt) cnt_r <= '0;
    else if (cmd.store && cnt_r < CW'(N)) cnt_r <= cnt_r + 1'b1;
  end

  // scan unit: one stored point a cycle
  logic          scan_busy_r, scan_done_r, have_r;
  logic [CW-1:0] si_r;
  logic [IW-1:0] best_r;
  logic [15:0]   bv_r;
  mpl_pkg::scan_t kind_r;
  logic [2:0]    dst_r;
  logic [15:0]   cur;
  logic          take;
  logic [IW-1:0] si;
  assign si = si_r[IW-1:0];
  always_comb begin
    cur = (kind_r == mpl_pkg::K_MIN_Y || kind_r == mpl_pkg::K_MAX_Y) ? ys_r[si] : xs_r[si];
    case (kind_r)
      mpl_pkg::K_MIN_Y, mpl_pkg::K_MIN_X: take = !have_r || cur < bv_r;
      mpl_pkg::K_MAX_Y, mpl_pkg::K_MAX_X: take = !have_r || cur > bv_r;
      mpl_pkg::K_LAST:  take = 1'b1;
      mpl_pkg::K_FIRST: take = !have_r;
      default:          take = 1'b0;
    endcase
    take = take && !ex_r[si];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_busy_r <= 1'b0;
      scan_done_r <= 1'b0;
    end else begin
      scan_done_r <= 1'b0;
      if (cmd.scan_go) begin
        scan_busy_r <= 1'b1;
      end else if (scan_busy_r && si_r == cnt_r - 1'b1) begin
        scan_busy_r <= 1'b0;
        scan_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_go) begin
      si_r <= '0; have_r <= 1'b0; best_r <= '0;
      kind_r <= cmd.kind; dst_r <= cmd.dst;
      if (cmd.dst == 3'd0) ex_r <= '0;
    end else if (scan_busy_r) begin
      si_r <= si_r + 1'b1;
      if (take) begin
        best_r <= si; bv_r <= cur; have_r <= 1'b1;
      end
      if (si_r == cnt_r - 1'b1) begin
        idx_r[dst_r] <= take ? si : best_r;
        ex_r[take ? si : best_r] <= 1'b1;
      end
    end else if (cmd.split) begin
      // idx 3 = c, 4 = d first two leftovers; 1 = a right, 2 = b left
      logic [IW-1:0] c, d;
      c = idx_r[3]; d = idx_r[4];
      if (xs_r[idx_r[3]] > xs_r[idx_r[4]]) begin c = idx_r[4]; d = idx_r[3]; end
      if (ys_r[idx_r[2]] < ys_r[c]) begin idx_r[4] <= idx_r[2]; idx_r[2] <= c; end
      else idx_r[4] <= c;
      if (ys_r[idx_r[1]] < ys_r[d]) begin idx_r[3] <= idx_r[1]; idx_r[1] <= d; end
      else idx_r[3] <= d;
    end
  end

  // deadzone check, one slot a cycle
  logic        chk_busy_r, chk_done_r, inside_r;
  logic [2:0]  ck_r;
  logic        in_x, in_y;
  logic [IW-1:0] ci;
  assign ci = idx_r[ck_r];

  function automatic logic in_square(input logic [15:0] s, input logic [15:0] q,
                                     input logic [7:0] h);
    logic signed [18:0] w, org, lim;
    logic signed [14:0] qd;
    logic [3:0] r;
    w  = $signed({3'b0, s}) - $signed({7'b0, h, 4'b0}) + 19'sd4096;
    qd = w[18:4];
    r  = w[3:0];
    if (r > 4'd8 || (r == 4'd8 && qd[0])) qd = qd + 15'sd1;
    org = $signed({qd - 15'sd256, 4'b0});
    lim = org + $signed({6'b0, h, 5'b0});
    in_square = (org <= $signed({3'b0, q})) && ($signed({3'b0, q}) < lim);
  endfunction

  assign in_x = in_square(dzx_r[ck_r], xs_r[ci], half_edge);
  assign in_y = in_square(dzy_r[ck_r], ys_r[ci], half_edge);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_busy_r <= 1'b0; chk_done_r <= 1'b0;
    end else begin
      chk_done_r <= 1'b0;
      if (cmd.chk_go) chk_busy_r <= 1'b1;
      else if (chk_busy_r && ck_r == need - 1'b1) begin
        chk_busy_r <= 1'b0; chk_done_r <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.chk_go) begin
      ck_r <= '0; inside_r <= 1'b1;
    end else if (chk_busy_r) begin
      ck_r <= ck_r + 1'b1;
      if (!(in_x && in_y)) inside_r <= 1'b0;
    end
  end

  logic held;
  logic [1:0] stat_r;
  assign held = half_edge != 8'd0 && armed_r && dzn_r == need && inside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0; dzn_r <= '0;
    end else if (dz_clear) begin
      armed_r <= 1'b0; dzn_r <= '0;
    end else if (cmd.commit && !held) begin
      armed_r <= half_edge != 8'd0;
      dzn_r   <= (half_edge != 8'd0) ? need : 3'd0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.commit) stat_r <= held ? mpl_pkg::StatHeld : mpl_pkg::StatMoved;
    if (cmd.commit && !held && half_edge != 8'd0) begin
      for (int k = 0; k < mpl_pkg::MaxModel; k++) begin
        dzx_r[k] <= xs_r[idx_r[k]];
        dzy_r[k] <= ys_r[idx_r[k]];
      end
    end
  end

  // result register
  logic        ebusy_r, vld_r, fail_r;
  logic [2:0]  ek_r;
  logic        advance;
  assign advance = !vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ebusy_r <= 1'b0; vld_r <= 1'b0;
    end else begin
      if (vld_r && !out_stall) vld_r <= 1'b0;
      if (cmd.emit_go || cmd.fail_go) ebusy_r <= 1'b1;
      else if (ebusy_r && advance) begin
        vld_r <= 1'b1;
        if (fail_r || ek_r == need - 1'b1) ebusy_r <= 1'b0;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.emit_go || cmd.fail_go) begin
      ek_r <= '0; fail_r <= cmd.fail_go;
    end else if (ebusy_r && advance) begin
      ek_r <= ek_r + 1'b1;
      out_slot <= fail_r ? 3'd0 : ek_r;
      out_out_x <= fail_r ? 16'd0 : xs_r[idx_r[ek_r]];
      out_out_y <= fail_r ? 16'd0 : ys_r[idx_r[ek_r]];
      out_source_index <= fail_r ? 3'd0 : 3'(idx_r[ek_r]);
      out_status <= fail_r ? mpl_pkg::StatFew : stat_r;
      out_last_result <= fail_r || ek_r == need - 1'b1;
    end
  end

  assign out_valid = vld_r;
  assign sts.scan_done = scan_done_r;
  assign sts.chk_done = chk_done_r;
  // controller waits until the last result has also left the register
  assign sts.emit_busy = ebusy_r || vld_r || cmd.emit_go || cmd.fail_go;
  assign sts.count = cnt_r;
endmodule
`default_nettype wire

@@ hw/rtl/marker_point_labeler.sv @@
// ----------------------------------------------------------------------------
// marker_point_labeler
// labels one frame of blob points by extremes and emits them in model order
// ----------------------------------------------------------------------------
// points are gathered one a cycle until the frame ends (last_point, or an
// empty item); the frame is then labelled by one scan of the stored points per
// model point, a split in five-point mode, a deadzone check and emission of
// the results; no new point is taken until the last result has left the
// output register. a frame with too few points gives a single result with
// status too few. writing the deadzone register clears the stored deadzones.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module marker_point_labeler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_point_valid,
  input  wire logic [15:0] in_point_x,
  input  wire logic [15:0] in_point_y,
  input  wire logic        in_last_point,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_slot,
  output logic [15:0]      out_out_x,
  output logic [15:0]      out_out_y,
  output logic [2:0]       out_source_index,
  output logic [1:0]       out_status,
  output logic             out_last_result,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);
  mpl_pkg::cmd_t cmd;
  mpl_pkg::sts_t sts;
  logic in_ready, in_xfer;
  logic [1:0] mode_r;
  logic [7:0] half_r;
  logic       dz_clear;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mpl_pkg::ModeCap3;
      half_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == mpl_pkg::CfgModelMode) mode_r <= cfg_data[1:0];
      else half_r <= cfg_data;
    end
  end
  assign dz_clear = cfg_we && cfg_index == mpl_pkg::CfgDeadzone;

  assign in_stall = !in_ready;
  assign in_xfer  = in_valid && in_ready;

  mpl_ctrl u_ctrl (
    .clk, .rst_n, .in_xfer, .in_point_valid, .in_last_point,
    .mode(mode_r), .sts, .cmd, .in_ready
  );

  mpl_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_point_x, .in_point_y,
    .mode(mode_r), .half_edge(half_r), .dz_clear,
    .out_valid, .out_stall, .out_slot, .out_out_x, .out_out_y,
    .out_source_index, .out_status, .out_last_result
  );

  // a too few result is always single and at slot zero
  `ASSERT_IMPL(a_few_single, clk, rst_n,
    (out_valid && out_status == mpl_pkg::StatFew) |-> (out_last_result && out_slot == 3'd0))
  // no point is taken while results are pending
  `ASSERT_NEVER(a_no_in_while_out, clk, rst_n, out_valid && in_ready)
endmodule
`default_nettype wire

@@ tb/sv/mpl_checker.sv @@
// ----------------------------------------------------------------------------
// mpl_checker
// predicts the labelled points of each frame and compares them with the dut
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mpl_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        in_point_valid,
  input  wire logic [15:0] in_point_x,
  input  wire logic [15:0] in_point_y,
  input  wire logic        in_last_point,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [2:0]  out_slot,
  input  wire logic [15:0] out_out_x,
  input  wire logic [15:0] out_out_y,
  input  wire logic [2:0]  out_source_index,
  input  wire logic [1:0]  out_status,
  input  wire logic        out_last_result,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  output int               fail_count,
  output int               pending
);
  typedef struct packed {
    logic [2:0]  slot;
    logic [15:0] x;
    logic [15:0] y;
    logic [2:0]  src;
    logic [1:0]  status;
    logic        last;
  } label_t;

  localparam int QDepth = 16;

  label_t      label_q[QDepth];
  int          q_wr = 0;
  int          q_rd = 0;
  logic [15:0] pts_x[mpl_pkg::MaxPoints];
  logic [15:0] pts_y[mpl_pkg::MaxPoints];
  int          pts_n;
  logic [15:0] hold_x[mpl_pkg::MaxModel];
  logic [15:0] hold_y[mpl_pkg::MaxModel];
  logic        hold_armed;
  int          hold_n;
  logic [1:0]  mode;
  logic [7:0]  half;

  assign pending = q_wr - q_rd;

  function automatic void put_label(input label_t l);
    label_q[q_wr % QDepth] = l;
    q_wr++;
  endfunction

  function automatic int scan_pick(input logic use_x, input int n, input int excl,
                                   input logic want_max);
    int best;
    logic have;
    logic [15:0] v, bv;
    best = 0;
    have = 0;
    for (int i = 0; i < n; i++) begin
      if (excl[i]) continue;
      v  = use_x ? pts_x[i] : pts_y[i];
      bv = use_x ? pts_x[best] : pts_y[best];
      if (!have || (want_max ? v > bv : v < bv)) begin
        best = i;
        have = 1;
      end
    end
    return best;
  endfunction

  function automatic logic in_box(input logic [15:0] centre, input logic [15:0] q,
                                  input logic [7:0] h);
    int w, qd, r, org;
    w  = int'(centre) - 16 * int'(h) + 4096;
    qd = w >>> 4;
    r  = w & 15;
    if (r > 8 || (r == 8 && qd[0])) qd++;
    org = (qd - 256) * 16;
    return org <= int'(q) && int'(q) < org + 32 * int'(h);
  endfunction

  task automatic label_frame();
    int n, need, ex, top, a, b, c, d, e;
    int idx[mpl_pkg::MaxModel];
    logic [1:0] st;
    label_t r;
    n = pts_n;
    pts_n = 0;
    need = (mode == mpl_pkg::ModeCap4) ? 4 : (mode == mpl_pkg::ModeCap5) ? 5 :
           mpl_pkg::MinModel;
    if (n < need) begin
      r = '{slot: 0, x: 0, y: 0, src: 0, status: mpl_pkg::StatFew, last: 1};
      put_label(r);
      return;
    end
    top = scan_pick(0, n, 0, 0);
    ex = 1 << top;
    if (mode == mpl_pkg::ModeClip) begin
      b = scan_pick(0, n, ex, 1);
      ex |= 1 << b;
      a = 0;
      for (int i = 0; i < n; i++) if (!ex[i]) a = i;
      idx[0] = top; idx[1] = a; idx[2] = b;
    end else begin
      a = scan_pick(1, n, ex, 1);
      ex |= 1 << a;
      b = scan_pick(1, n, ex, 0);
      ex |= 1 << b;
      idx[0] = top; idx[1] = a; idx[2] = b;
      if (mode == mpl_pkg::ModeCap4) begin
        idx[3] = 0;
        for (int i = 0; i < n; i++) if (!ex[i]) idx[3] = i;
      end else if (mode == mpl_pkg::ModeCap5) begin
        c = 0;
        for (int i = n - 1; i >= 0; i--) if (!ex[i]) c = i;
        d = 0;
        for (int i = n - 1; i >= 0; i--) if (!ex[i] && i != c) d = i;
        if (pts_x[c] > pts_x[d]) begin
          e = c; c = d; d = e;
        end
        // smaller y on each side becomes the top corner
        if (pts_y[b] < pts_y[c]) begin
          idx[4] = b; idx[2] = c;
        end else idx[4] = c;
        if (pts_y[a] < pts_y[d]) begin
          idx[3] = a; idx[1] = d;
        end else idx[3] = d;
      end
    end
    st = mpl_pkg::StatMoved;
    if (half != 0 && hold_armed && hold_n == need) begin
      st = mpl_pkg::StatHeld;
      for (int k = 0; k < need; k++)
        if (!in_box(hold_x[k], pts_x[idx[k]], half) ||
            !in_box(hold_y[k], pts_y[idx[k]], half)) st = mpl_pkg::StatMoved;
    end
    if (st == mpl_pkg::StatMoved) begin
      if (half != 0) begin
        for (int k = 0; k < need; k++) begin
          hold_x[k] = pts_x[idx[k]];
          hold_y[k] = pts_y[idx[k]];
        end
        hold_armed = 1;
        hold_n = need;
      end else begin
        hold_armed = 0;
        hold_n = 0;
      end
    end
    for (int k = 0; k < need; k++) begin
      r = '{slot: 3'(k), x: pts_x[idx[k]], y: pts_y[idx[k]], src: 3'(idx[k]),
            status: st, last: (k + 1 == need)};
      put_label(r);
    end
  endtask

  always @(posedge clk) begin
    label_t exp_l;
    if (!rst_n) begin
      pts_n = 0;
      hold_armed = 0;
      hold_n = 0;
      mode = mpl_pkg::ModeCap3;
      half = 0;
      fail_count = 0;
      q_wr = 0;
      q_rd = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == mpl_pkg::CfgModelMode) mode = cfg_data[1:0];
        else begin
          half = cfg_data;
          hold_armed = 0;
          hold_n = 0;
        end
      end
      if (in_valid && !in_stall) begin
        if (in_point_valid) begin
          if (pts_n < mpl_pkg::MaxPoints) begin
            pts_x[pts_n] = in_point_x;
            pts_y[pts_n] = in_point_y;
            pts_n++;
          end
          if (in_last_point) label_frame();
        end else label_frame();
      end
      if (out_valid && !out_stall) begin
        if (q_wr == q_rd) begin
          $error("unexpected result slot %0d", out_slot);
          fail_count++;
        end else begin
          exp_l = label_q[q_rd % QDepth];
          q_rd++;
          if (out_slot !== exp_l.slot) begin
            $error("slot exp %0d got %0d", exp_l.slot, out_slot); fail_count++;
          end
          if (out_out_x !== exp_l.x) begin
            $error("out_x exp %h got %h", exp_l.x, out_out_x); fail_count++;
          end
          if (out_out_y !== exp_l.y) begin
            $error("out_y exp %h got %h", exp_l.y, out_out_y); fail_count++;
          end
          if (out_source_index !== exp_l.src) begin
            $error("source_index exp %0d got %0d", exp_l.src, out_source_index);
            fail_count++;
          end
          if (out_status !== exp_l.status) begin
            $error("status exp %0d got %0d", exp_l.status, out_status); fail_count++;
          end
          if (out_last_result !== exp_l.last) begin
            $error("last_result exp %0d got %0d", exp_l.last, out_last_result);
            fail_count++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the marker point labeler
// ----------------------------------------------------------------------------
// frames of blob points are sent in every model mode and varied deadzone sizes;
// jittered repeats of a frame test the held status, short frames the fail result
`timescale 1ns / 1ps
`default_nettype none
module tb;
  localparam int CycleLimit = 400000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        in_point_valid = 0;
  logic [15:0] in_point_x = 0;
  logic [15:0] in_point_y = 0;
  logic        in_last_point = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  out_slot;
  logic [15:0] out_out_x;
  logic [15:0] out_out_y;
  logic [2:0]  out_source_index;
  logic [1:0]  out_status;
  logic        out_last_result;
  logic        cfg_we = 0;
  logic        cfg_index = mpl_pkg::CfgModelMode;
  logic [7:0]  cfg_data = 0;
  int          fail_count;
  int          pending;
  int          cycles = 0;

  // frame memory for jittered repeats
  logic [15:0] base_x[mpl_pkg::MaxPoints];
  logic [15:0] base_y[mpl_pkg::MaxPoints];

  always #2 clk = ~clk;

  marker_point_labeler dut (.*);

  mpl_checker chk (.*);

  // receiver stalls a random number of cycles per result
  always @(posedge clk) begin
    int gap;
    if (out_valid && !out_stall) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap != 0) out_stall <= 1;
      fork : stall_hold
        begin
          repeat (gap) @(posedge clk);
          out_stall <= 0;
        end
      join_none
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one transfer on the input channel, after a random gap
  task automatic send_item(input logic pv, input logic [15:0] x, input logic [15:0] y,
                           input logic last, input logic no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1;
    in_point_valid <= pv;
    in_point_x     <= x;
    in_point_y     <= y;
    in_last_point  <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    drain();
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // send n points; jitter of zero means fresh random points
  task automatic send_frame(input int n, input int jitter, input logic end_empty,
                            input logic fast);
    logic [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      if (jitter < 0 || i >= mpl_pkg::MaxPoints) begin
        x = 16'($urandom); y = 16'($urandom);
      end else if (jitter == 0) begin
        x = 16'($urandom); y = 16'($urandom);
        base_x[i] = x; base_y[i] = y;
      end else begin
        x = base_x[i] + 16'($urandom_range(0, 2 * jitter)) - 16'(jitter);
        y = base_y[i] + 16'($urandom_range(0, 2 * jitter)) - 16'(jitter);
      end
      send_item(1, x, y, !end_empty && i == n - 1, fast);
    end
    if (end_empty)
      send_item(0, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)), fast);
  endtask

  initial begin
    int n, mode;
    for (int i = 0; i < mpl_pkg::MaxPoints; i++) begin
      base_x[i] = 16'($urandom);
      base_y[i] = 16'($urandom);
    end
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, ties, every mode, short frames, overflow
    send_item(1, 16'hFFFF, 16'h0000, 0, 1);
    send_item(1, 16'h0000, 16'hFFFF, 0, 1);
    send_item(1, 16'h0000, 16'hFFFF, 1, 0);
    send_item(1, 16'h1234, 16'h0010, 1, 0);
    send_item(0, 16'hFFFF, 16'hFFFF, 1, 0);
    for (int m = 0; m < 4; m++) begin
      write_reg(mpl_pkg::CfgModelMode, 8'(m));
      for (int i = 0; i < 5; i++) send_item(1, 16'h0000, 16'h0000, i == 4, 1);
      send_item(1, 16'hAAAA, 16'h5555, 0, 0);
      send_item(1, 16'h5555, 16'hAAAA, 0, 0);
      send_item(0, 0, 0, 0, 0);
    end
    send_frame(10, -1, 0, 1);

    // random: frames in random modes, deadzone sizes incl. the extremes
    for (int ph = 0; ph < 7; ph++) begin
      mode = $urandom_range(0, 3);
      write_reg(mpl_pkg::CfgModelMode, 8'(mode));
      write_reg(mpl_pkg::CfgDeadzone, (ph == 1) ? 8'd255 : (ph == 2) ? 8'd0 :
                (ph == 3) ? 8'd1 : 8'($urandom_range(0, 40)));
      for (int f = 0; f < 4; f++) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 10) : $urandom_range(3, 6);
        send_frame(n, (f == 0) ? 0 : ($urandom_range(0, 3) == 0 ? 0 :
                   $urandom_range(1, 40)), $urandom_range(0, 4) == 0,
                   $urandom_range(0, 3) == 0);
      end
      if (ph == 4) drain();
    end

    drain();
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

@@ marker_point_labeler.f @@
+incdir+hw/rtl
hw/rtl/mpl_pkg.sv
hw/rtl/mpl_ctrl.sv
hw/rtl/mpl_datapath.sv
hw/rtl/marker_point_labeler.sv
tb/sv/mpl_checker.sv
tb/sv/tb.sv
